[rtl/rps_pkg.sv]
package rps_pkg;

  // pixel format codes
  localparam logic [2:0] FMT_S8  = 3'd0;
  localparam logic [2:0] FMT_U8  = 3'd1;
  localparam logic [2:0] FMT_S16 = 3'd2;
  localparam logic [2:0] FMT_U16 = 3'd3;
  localparam logic [2:0] FMT_S32 = 3'd4;
  localparam logic [2:0] FMT_U32 = 3'd5;

  // register indexes
  localparam logic [2:0] REG_PIXEL_FORMAT = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [2:0] REG_ROI_LEFT     = 3'd2;
  localparam logic [2:0] REG_ROI_TOP      = 3'd3;
  localparam logic [2:0] REG_ROI_RIGHT    = 3'd4;
  localparam logic [2:0] REG_ROI_BOTTOM   = 3'd5;

  localparam int POS_W   = 13;
  localparam int VAL_W   = 33;
  localparam int CNT_W   = 25;
  localparam int SUM_W   = 58;
  localparam int SMAG_W  = 57;
  localparam int SQS_W   = 89;
  localparam int PROD_W  = 115;
  localparam int DIVD_W  = 131;
  localparam int NSQ_W   = 50;
  localparam int RAD_W   = 82;
  localparam int ROOT_W  = 41;
  localparam int SREM_W  = 43;
  localparam int STD_W   = 40;

  localparam logic [CNT_W-1:0] COUNT_FULL = {CNT_W{1'b1}};
  localparam logic [POS_W-1:0] ROW_TOP    = {POS_W{1'b1}};

  // iteration counts of the back end
  localparam int QN_STEPS   = CNT_W;
  localparam int SS_STEPS   = SMAG_W;
  localparam int MEAN_STEPS = SMAG_W;
  localparam int VAR_STEPS  = DIVD_W;
  localparam int ROOT_STEPS = ROOT_W;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_QN,
    OP_SS,
    OP_SUB,
    OP_MEAN,
    OP_VAR,
    OP_ROOT,
    OP_FINISH
  } rps_op_t;

  typedef struct packed {
    rps_op_t op;
    logic    load;
  } rps_cmd_t;

  typedef struct packed {
    logic flushed;
    logic count_zero;
    logic out_busy;
  } rps_status_t;

  typedef struct packed {
    logic [2:0]       pixel_format;
    logic [POS_W-1:0] image_width;
    logic [POS_W-1:0] roi_left;
    logic [POS_W-1:0] roi_top;
    logic [POS_W-1:0] roi_right;
    logic [POS_W-1:0] roi_bottom;
  } rps_cfg_t;

endpackage

[rtl/rps_ctrl.sv]
module rps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                frame_end,
  input  rps_pkg::rps_status_t status,
  output rps_pkg::rps_cmd_t   cmd,
  output logic                busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FLUSH,
    S_QN,
    S_SS,
    S_SUB,
    S_MEAN,
    S_VAR,
    S_ROOT,
    S_FINISH
  } state_t;

  state_t     state;
  logic       first;
  logic [7:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && frame_end) state <= S_FLUSH;
        end
        S_FLUSH: begin
          if (status.flushed) begin
            state <= status.count_zero ? S_FINISH : S_QN;
            first <= 1'b1;
          end
        end
        S_QN, S_SS, S_MEAN, S_VAR, S_ROOT: begin
          if (first) begin
            first <= 1'b0;
            unique case (state)
              S_QN:    cnt <= 8'(rps_pkg::QN_STEPS - 1);
              S_SS:    cnt <= 8'(rps_pkg::SS_STEPS - 1);
              S_MEAN:  cnt <= 8'(rps_pkg::MEAN_STEPS - 1);
              S_VAR:   cnt <= 8'(rps_pkg::VAR_STEPS - 1);
              default: cnt <= 8'(rps_pkg::ROOT_STEPS - 1);
            endcase
          end else if (cnt == 8'd0) begin
            first <= 1'b1;
            unique case (state)
              S_QN:    state <= S_SS;
              S_SS:    state <= S_SUB;
              S_MEAN:  state <= S_VAR;
              S_VAR:   state <= S_ROOT;
              default: state <= S_FINISH;
            endcase
          end else begin
            cnt <= cnt - 8'd1;
          end
        end
        S_SUB: begin
          state <= S_MEAN;
          first <= 1'b1;
        end
        S_FINISH: begin
          if (!status.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.load = first;
    unique case (state)
      S_QN:     cmd.op = rps_pkg::OP_QN;
      S_SS:     cmd.op = rps_pkg::OP_SS;
      S_SUB:    cmd.op = rps_pkg::OP_SUB;
      S_MEAN:   cmd.op = rps_pkg::OP_MEAN;
      S_VAR:    cmd.op = rps_pkg::OP_VAR;
      S_ROOT:   cmd.op = rps_pkg::OP_ROOT;
      S_FINISH: cmd.op = status.out_busy ? rps_pkg::OP_NONE : rps_pkg::OP_FINISH;
      default:  cmd.op = rps_pkg::OP_NONE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

[rtl/rps_datapath.sv]
module rps_datapath #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rps_pkg::rps_cfg_t    cfg,
  input  logic                 accept,
  input  logic [31:0]          pixel_word,
  input  logic                 frame_end,
  input  rps_pkg::rps_cmd_t    cmd,
  output rps_pkg::rps_status_t status,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic signed [32:0]   mean_value,
  output logic [39:0]          std_dev,
  output logic signed [32:0]   max_value,
  output logic signed [32:0]   min_value,
  output logic [24:0]          pixel_total,
  output logic                 region_empty
);

  localparam logic [14:0] MAX_W = 15'(MAX_WIDTH);
  localparam logic [14:0] MAX_H = 15'(MAX_HEIGHT);

  // raster position
  logic [rps_pkg::POS_W-1:0] column, row;
  logic [14:0]               wlim;
  logic                      col_wrap, in_roi;
  logic signed [32:0]        v_dec;

  always_comb begin
    if (cfg.image_width == '0) wlim = 15'd1;
    else if ({2'b0, cfg.image_width} > MAX_W) wlim = MAX_W;
    else wlim = {2'b0, cfg.image_width};
    col_wrap = ({2'b0, column} + 15'd1) >= wlim;
    in_roi = (column >= cfg.roi_left) && (column < cfg.roi_right) &&
             (row >= cfg.roi_top) && (row < cfg.roi_bottom) && ({2'b0, row} < MAX_H);
    case (cfg.pixel_format)
      rps_pkg::FMT_S8:  v_dec = {{25{pixel_word[7]}}, pixel_word[7:0]};
      rps_pkg::FMT_U8:  v_dec = {25'b0, pixel_word[7:0]};
      rps_pkg::FMT_S16: v_dec = {{17{pixel_word[15]}}, pixel_word[15:0]};
      rps_pkg::FMT_U16: v_dec = {17'b0, pixel_word[15:0]};
      rps_pkg::FMT_S32: v_dec = {pixel_word[31], pixel_word};
      default:          v_dec = {1'b0, pixel_word};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (accept) begin
      if (frame_end) begin
        column <= '0;
        row    <= '0;
      end else if (col_wrap) begin
        column <= '0;
        if (row != rps_pkg::ROW_TOP) row <= row + 1'b1;
      end else begin
        column <= column + 1'b1;
      end
    end
  end

  // stage a: decoded pixel
  logic               a_valid, a_in, a_end;
  logic signed [32:0] a_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_end   <= 1'b0;
    end else begin
      a_valid <= accept;
      a_end   <= accept & frame_end;
    end
    a_v  <= v_dec;
    a_in <= in_roi;
  end

  // stage b: count, sum, extremes, square; then the square sum
  logic [rps_pkg::CNT_W-1:0]        count;
  logic signed [rps_pkg::SUM_W-1:0] vsum;
  logic signed [32:0]               largest, smallest;
  logic [rps_pkg::SQS_W-1:0]        sqsum;
  logic [63:0]                      sq;
  logic                             b_add, b_end, c_end, take;
  logic [32:0]                      a_neg;
  logic [31:0]                      mag;

  assign take  = a_valid && a_in && (count != rps_pkg::COUNT_FULL);
  assign a_neg = -a_v;
  assign mag   = a_v[32] ? a_neg[31:0] : a_v[31:0];

  always_ff @(posedge clk) begin
    if (rst || cmd.op == rps_pkg::OP_FINISH) begin
      count    <= '0;
      vsum     <= '0;
      largest  <= {1'b1, 32'b0};
      smallest <= {1'b0, {32{1'b1}}};
      sqsum    <= '0;
      b_add    <= 1'b0;
      b_end    <= 1'b0;
      c_end    <= 1'b0;
    end else begin
      if (take) begin
        count <= count + 1'b1;
        vsum  <= vsum + {{(rps_pkg::SUM_W-33){a_v[32]}}, a_v};
        if (a_v > largest)  largest  <= a_v;
        if (a_v < smallest) smallest <= a_v;
      end
      b_add <= take;
      b_end <= a_valid & a_end;
      if (b_add) sqsum <= sqsum + {25'b0, sq};
      c_end <= b_end;
    end
    sq <= {32'b0, mag} * {32'b0, mag};
  end

  // back end: shift-add multiplier, restoring divider, digit square root
  logic [rps_pkg::SMAG_W-1:0] smag;
  logic [rps_pkg::SUM_W-1:0]  sum_neg;
  logic [rps_pkg::PROD_W-1:0] mul_acc, dreg, mul_add;
  logic [rps_pkg::SMAG_W-1:0] mul_b;
  logic [rps_pkg::NSQ_W-1:0]  nsq, dv;
  logic [rps_pkg::DIVD_W-1:0] div_q;
  logic [rps_pkg::NSQ_W-1:0]  div_r;
  logic [rps_pkg::NSQ_W:0]    div_rs, div_sub;
  logic                       div_ge;
  logic [rps_pkg::RAD_W-1:0]  rad;
  logic [rps_pkg::ROOT_W-1:0] root;
  logic [rps_pkg::SREM_W-1:0] srem;
  logic [rps_pkg::SREM_W+1:0] sq_rp, sq_trial;
  logic                       sq_ge;
  logic signed [32:0]         mean;
  logic [32:0]                q33;
  logic [32:0]                q33_neg;

  assign sum_neg = -vsum;
  assign smag    = vsum[rps_pkg::SUM_W-1] ? sum_neg[rps_pkg::SMAG_W-1:0]
                                          : vsum[rps_pkg::SMAG_W-1:0];

  always_comb begin
    if (cmd.op == rps_pkg::OP_QN)
      mul_add = mul_b[rps_pkg::SMAG_W-1] ? {26'b0, sqsum} : '0;
    else
      mul_add = mul_b[rps_pkg::SMAG_W-1] ? {58'b0, smag} : '0;
    dv       = (cmd.op == rps_pkg::OP_MEAN) ? {25'b0, count} : nsq;
    div_rs   = {div_r, div_q[rps_pkg::DIVD_W-1]};
    div_ge   = div_rs >= {1'b0, dv};
    div_sub  = div_rs - {1'b0, dv};
    sq_rp    = {srem, rad[rps_pkg::RAD_W-1 -: 2]};
    sq_trial = {2'b0, root, 2'b01};
    sq_ge    = sq_rp >= sq_trial;
    q33      = div_q[32:0];
    q33_neg  = -q33;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rps_pkg::OP_QN: begin
        if (cmd.load) begin
          mul_acc <= '0;
          mul_b   <= {count, 32'b0};
        end else begin
          mul_acc <= {mul_acc[rps_pkg::PROD_W-2:0], 1'b0} + mul_add;
          mul_b   <= {mul_b[rps_pkg::SMAG_W-2:0], 1'b0};
        end
      end
      rps_pkg::OP_SS: begin
        if (cmd.load) begin
          dreg    <= mul_acc;
          mul_acc <= '0;
          mul_b   <= smag;
        end else begin
          mul_acc <= {mul_acc[rps_pkg::PROD_W-2:0], 1'b0} + mul_add;
          mul_b   <= {mul_b[rps_pkg::SMAG_W-2:0], 1'b0};
        end
      end
      rps_pkg::OP_SUB: begin
        dreg <= (mul_acc <= dreg) ? dreg - mul_acc : '0;
        nsq  <= {25'b0, count} * {25'b0, count};
      end
      rps_pkg::OP_MEAN, rps_pkg::OP_VAR: begin
        if (cmd.load) begin
          div_r <= '0;
          if (cmd.op == rps_pkg::OP_MEAN) begin
            div_q <= {smag, 74'b0};
          end else begin
            div_q <= {dreg, 16'b0};
            mean  <= vsum[rps_pkg::SUM_W-1] ? q33_neg : q33;
          end
        end else begin
          div_r <= div_ge ? div_sub[rps_pkg::NSQ_W-1:0] : div_rs[rps_pkg::NSQ_W-1:0];
          div_q <= {div_q[rps_pkg::DIVD_W-2:0], div_ge};
        end
      end
      rps_pkg::OP_ROOT: begin
        if (cmd.load) begin
          rad  <= div_q[rps_pkg::RAD_W-1:0];
          root <= '0;
          srem <= '0;
        end else begin
          srem <= sq_ge ? rps_pkg::SREM_W'(sq_rp - sq_trial) : sq_rp[rps_pkg::SREM_W-1:0];
          root <= {root[rps_pkg::ROOT_W-2:0], sq_ge};
          rad  <= {rad[rps_pkg::RAD_W-3:0], 2'b00};
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == rps_pkg::OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.op == rps_pkg::OP_FINISH) begin
      if (count == '0) begin
        mean_value   <= '0;
        std_dev      <= '0;
        max_value    <= '0;
        min_value    <= '0;
        pixel_total  <= '0;
        region_empty <= 1'b1;
      end else begin
        mean_value   <= mean;
        std_dev      <= root[rps_pkg::STD_W-1:0];
        max_value    <= largest;
        min_value    <= smallest;
        pixel_total  <= count;
        region_empty <= 1'b0;
      end
    end
  end

  assign status.flushed    = c_end;
  assign status.count_zero = (count == '0);
  assign status.out_busy   = out_valid & out_stall;

endmodule

[rtl/roi_pixel_statistics_core.sv]
// statistics of the pixels inside a rectangle of a raster-scanned image
//
// input channel: one pixel item per accepted cycle (in_valid high, in_stall
// low), raw pixel_word read per pixel_format, frame_end on the last pixel
// output channel: one result item per frame (mean, std_dev with 8 fraction
// bits, max, min, pixel_total, region_empty), held until out_stall is low
// throughput: one pixel per cycle inside a frame; the three-stage front end
// (decode and window test, count/sum/extremes and square, square sum)
// keeps up with the stream
// frame end: after a frame_end item in_stall stays high while the back end
// runs: first a flush of the front end, then the serial arithmetic
// (shift-add products, a 131-bit restoring divide, a 41-step square root);
// an empty window skips the arithmetic and its result follows the flush
// a finished result waits in the output register while the next frame
// streams in; a second result waits for the first to be taken
// configuration: apb-style port, registers at byte addresses 0,4,...,20,
// written only while no frame is in flight; the user keeps this, unchecked
// reset: synchronous, clears position, statistics and registers to defaults
module roi_pixel_statistics_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  // pixel items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        pixel_word,
  input  logic               frame_end,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [32:0] mean_value,
  output logic [39:0]        std_dev,
  output logic signed [32:0] max_value,
  output logic signed [32:0] min_value,
  output logic [24:0]        pixel_total,
  output logic               region_empty,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  rps_pkg::rps_cfg_t    cfg;
  rps_pkg::rps_cmd_t    cmd;
  rps_pkg::rps_status_t status;
  logic                 accept, busy, cfg_we;
  logic [2:0]           reg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format <= rps_pkg::FMT_U16;
      cfg.image_width  <= 13'd512;
      cfg.roi_left     <= '0;
      cfg.roi_top      <= '0;
      cfg.roi_right    <= '0;
      cfg.roi_bottom   <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        rps_pkg::REG_PIXEL_FORMAT: cfg.pixel_format <= pwdata[2:0];
        rps_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[12:0];
        rps_pkg::REG_ROI_LEFT:     cfg.roi_left     <= pwdata[12:0];
        rps_pkg::REG_ROI_TOP:      cfg.roi_top      <= pwdata[12:0];
        rps_pkg::REG_ROI_RIGHT:    cfg.roi_right    <= pwdata[12:0];
        rps_pkg::REG_ROI_BOTTOM:   cfg.roi_bottom   <= pwdata[12:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rps_pkg::REG_PIXEL_FORMAT: prdata = {29'b0, cfg.pixel_format};
      rps_pkg::REG_IMAGE_WIDTH:  prdata = {19'b0, cfg.image_width};
      rps_pkg::REG_ROI_LEFT:     prdata = {19'b0, cfg.roi_left};
      rps_pkg::REG_ROI_TOP:      prdata = {19'b0, cfg.roi_top};
      rps_pkg::REG_ROI_RIGHT:    prdata = {19'b0, cfg.roi_right};
      rps_pkg::REG_ROI_BOTTOM:   prdata = {19'b0, cfg.roi_bottom};
      default:                   prdata = '0;
    endcase
  end

  // pixels are taken only while the controller is idle
  assign in_stall = busy;
  assign accept   = in_valid & ~in_stall;

  rps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .frame_end (frame_end),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  rps_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .pixel_word   (pixel_word),
    .frame_end    (frame_end),
    .cmd          (cmd),
    .status       (status),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .mean_value   (mean_value),
    .std_dev      (std_dev),
    .max_value    (max_value),
    .min_value    (min_value),
    .pixel_total  (pixel_total),
    .region_empty (region_empty)
  );

  // the frame-end item closes the input until its result is built
  a_end_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && frame_end) |=> in_stall)
    else $error("input not closed after frame end");

  // an empty window reports a zero count
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && region_empty) |-> (pixel_total == '0))
    else $error("empty result with nonzero count");

  // extremes of a nonempty window are ordered
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !region_empty) |-> ($signed(min_value) <= $signed(max_value)))
    else $error("min above max");

  // a result appears only while the back end is working
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy))
    else $error("result without a frame");

endmodule

[tb/roi_pixel_statistics_core_tb.sv]
`default_nettype none

module roi_pixel_statistics_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one pixel item as queued for the driver
  typedef struct {
    logic [31:0] word;
    logic        last;
  } pixel_item_t;

  // one frame result as the block should report it
  typedef struct {
    logic signed [32:0] mean;
    logic [39:0]        spread;
    logic signed [32:0] hi_val;
    logic signed [32:0] lo_val;
    logic [24:0]        total;
    logic               empty;
  } frame_stats_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        pixel_word = '0;
  logic               frame_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [32:0] mean_value;
  logic [39:0]        std_dev;
  logic signed [32:0] max_value;
  logic signed [32:0] min_value;
  logic [24:0]        pixel_total;
  logic               region_empty;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  roi_pixel_statistics_core dut (.*);

  always #5 clk = ~clk;

  // pending pixel items and expected frame results
  pixel_item_t  pixel_q[$];
  frame_stats_t stats_q[$];
  int           error_count = 0;
  int           pushed_items = 0;

  // idling controls set per phase by the stimulus
  bit sender_gaps = 1'b1;
  bit recv_gaps   = 1'b1;
  bit hold_req    = 1'b0;
  int quiet_cycles = 0;

  // predictor copy of the registers
  logic [2:0]  fmt_reg   = rps_pkg::FMT_U16;
  logic [12:0] width_reg = 13'd512;
  logic [12:0] left_reg  = '0;
  logic [12:0] top_reg   = '0;
  logic [12:0] right_reg = '0;
  logic [12:0] bot_reg   = '0;

  // predictor copy of the running statistics
  int           col_pos = 0;
  int           row_pos = 0;
  longint       run_sum = 0;
  logic [127:0] run_sq  = '0;
  longint       run_max = -64'sd4294967296;
  longint       run_min = 64'sd4294967295;
  int           run_cnt = 0;

  function automatic longint pixel_value(logic [31:0] w);
    case (fmt_reg)
      rps_pkg::FMT_S8:  return longint'($signed(w[7:0]));
      rps_pkg::FMT_U8:  return longint'({1'b0, w[7:0]});
      rps_pkg::FMT_S16: return longint'($signed(w[15:0]));
      rps_pkg::FMT_U16: return longint'({1'b0, w[15:0]});
      rps_pkg::FMT_S32: return longint'($signed(w));
      default:          return longint'({1'b0, w});
    endcase
  endfunction

  // floor(256 * sqrt(population variance)), all in exact integers
  function automatic logic [39:0] spread_of(logic [127:0] sq, longint s, int n);
    logic [191:0] d, t, q, c, res, nn;
    logic [63:0]  smag;
    smag = s < 0 ? 64'(-s) : 64'(s);
    nn = 192'(n);
    d = 192'(sq) * nn;
    t = 192'(smag) * 192'(smag);
    d = (t <= d) ? d - t : '0;
    q = (d << 16) / (nn * nn);
    res = '0;
    for (int b = 40; b >= 0; b--) begin
      c = res | (192'd1 << b);
      if (c * c <= q) res = c;
    end
    return res[39:0];
  endfunction

  // fold one accepted pixel into the statistics, queue a result on frame end
  function automatic void take_pixel(logic [31:0] w, logic last);
    longint       v;
    longint       mag;
    int           eff_w;
    frame_stats_t r;
    v = pixel_value(w);
    eff_w = (width_reg == 0) ? 1 : int'(width_reg);
    if (eff_w > 4096) eff_w = 4096;
    if (col_pos >= left_reg && col_pos < right_reg && row_pos >= top_reg &&
        row_pos < bot_reg && row_pos < 4096 && run_cnt < int'(rps_pkg::COUNT_FULL)) begin
      mag = v < 0 ? -v : v;
      run_cnt++;
      run_sum += v;
      run_sq += 128'(mag) * 128'(mag);
      if (v > run_max) run_max = v;
      if (v < run_min) run_min = v;
    end
    if (col_pos + 1 >= eff_w) begin
      col_pos = 0;
      if (row_pos < int'(rps_pkg::ROW_TOP)) row_pos++;
    end else begin
      col_pos++;
    end
    if (!last) return;
    if (run_cnt == 0) begin
      r = '{mean: '0, spread: '0, hi_val: '0, lo_val: '0, total: '0, empty: 1'b1};
    end else begin
      r.mean   = 33'(run_sum / longint'(run_cnt));
      r.spread = spread_of(run_sq, run_sum, run_cnt);
      r.hi_val = 33'(run_max);
      r.lo_val = 33'(run_min);
      r.total  = 25'(run_cnt);
      r.empty  = 1'b0;
    end
    stats_q.push_back(r);
    col_pos = 0; row_pos = 0; run_sum = 0; run_sq = '0; run_cnt = 0;
    run_max = -64'sd4294967296;
    run_min = 64'sd4294967295;
  endfunction

  // pixel driver: a gap drawn per item, valid held until accepted
  int send_gap = 0;
  always @(posedge clk) begin
    logic        nv;
    pixel_item_t it;
    nv = in_valid;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        take_pixel(pixel_word, frame_end);
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pixel_q.size() > 0) begin
          it = pixel_q.pop_front();
          pixel_word <= it.word;
          frame_end  <= it.last;
          nv = 1'b1;
          send_gap = sender_gaps ? $urandom_range(0, 8) : 0;
        end
      end
    end
    in_valid <= nv;
  end

  // result monitor and stall generator
  int recv_gap = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    frame_stats_t e;
    if (!rst && out_valid && !out_stall) begin
      if (stats_q.size() == 0) begin
        $error("result with nothing expected");
        error_count++;
      end else begin
        e = stats_q.pop_front();
        if (mean_value !== e.mean) begin
          $error("mean_value exp %0d got %0d", e.mean, mean_value); error_count++;
        end
        if (std_dev !== e.spread) begin
          $error("std_dev exp %0d got %0d", e.spread, std_dev); error_count++;
        end
        if (max_value !== e.hi_val) begin
          $error("max_value exp %0d got %0d", e.hi_val, max_value); error_count++;
        end
        if (min_value !== e.lo_val) begin
          $error("min_value exp %0d got %0d", e.lo_val, min_value); error_count++;
        end
        if (pixel_total !== e.total) begin
          $error("pixel_total exp %0d got %0d", e.total, pixel_total); error_count++;
        end
        if (region_empty !== e.empty) begin
          $error("region_empty exp %0d got %0d", e.empty, region_empty); error_count++;
        end
      end
      recv_gap = recv_gaps ? $urandom_range(0, 8) : 0;
    end
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // register write: setup then access cycle
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      rps_pkg::REG_PIXEL_FORMAT: fmt_reg   = val[2:0];
      rps_pkg::REG_IMAGE_WIDTH:  width_reg = val[12:0];
      rps_pkg::REG_ROI_LEFT:     left_reg  = val[12:0];
      rps_pkg::REG_ROI_TOP:      top_reg   = val[12:0];
      rps_pkg::REG_ROI_RIGHT:    right_reg = val[12:0];
      rps_pkg::REG_ROI_BOTTOM:   bot_reg   = val[12:0];
      default: ;
    endcase
  endtask

  task automatic set_window(logic [2:0] f, int w, int l, int t, int r, int b);
    reg_write(rps_pkg::REG_PIXEL_FORMAT, 32'(f));
    reg_write(rps_pkg::REG_IMAGE_WIDTH, 32'(w));
    reg_write(rps_pkg::REG_ROI_LEFT, 32'(l));
    reg_write(rps_pkg::REG_ROI_TOP, 32'(t));
    reg_write(rps_pkg::REG_ROI_RIGHT, 32'(r));
    reg_write(rps_pkg::REG_ROI_BOTTOM, 32'(b));
  endtask

  // pixel word with extremes mixed into random data
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return {16'($urandom_range(0, 65535)), 16'h8000};
      5: return {24'($urandom), 8'h80};
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_frame(int n);
    for (int i = 0; i < n; i++)
      pixel_q.push_back('{word: pick_word(), last: (i == n - 1)});
    pushed_items += n;
  endtask

  // sender pause until every expected result is back, then let the back end settle
  task automatic drain();
    while (pixel_q.size() > 0 || in_valid || stats_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    int w;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults give an empty window
    queue_frame(3);
    drain();
    // whole small image, every format in turn
    for (int f = 0; f < 8; f++) begin
      set_window(3'(f), 3, 0, 0, 3, 2);
      queue_frame(6);
      drain();
    end
    // width zero acts as one, oversized width clamps, inverted and extreme bounds
    set_window(rps_pkg::FMT_S32, 0, 0, 1, 1, 3);
    queue_frame(4);
    drain();
    set_window(rps_pkg::FMT_U32, 8191, 4094, 0, 8191, 1);
    queue_frame(5);
    drain();
    set_window(rps_pkg::FMT_S16, 4, 3, 2, 1, 4);
    queue_frame(8);
    drain();
    set_window(rps_pkg::FMT_U8, 4096, 0, 0, 4096, 4096);
    queue_frame(7);
    drain();
    // writes outside the register map are dropped
    reg_write(3'd6, 32'h1);
    reg_write(3'd7, 32'h0);

    // long receiver hold while frames keep coming
    set_window(rps_pkg::FMT_S16, 5, 1, 1, 4, 5);
    hold_req = 1'b1;
    for (int k = 0; k < 4; k++) queue_frame($urandom_range(10, 30));
    drain();

    // random windows and frames
    while (pushed_items < 1500) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      recv_gaps = ($urandom_range(0, 3) != 0);
      w = $urandom_range(1, 12);
      set_window(3'($urandom_range(0, 7)), w, $urandom_range(0, w), $urandom_range(0, 4),
                 ($urandom_range(0, 9) == 0) ? 4096 : $urandom_range(0, w + 1),
                 ($urandom_range(0, 9) == 0) ? 8191 : $urandom_range(0, 6));
      for (int k = $urandom_range(1, 3); k > 0; k--) queue_frame($urandom_range(1, 40));
      drain();
    end

    if (stats_q.size() != 0) begin
      $error("%0d results never arrived", stats_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/rps_pkg.sv
rtl/rps_ctrl.sv
rtl/rps_datapath.sv
rtl/roi_pixel_statistics_core.sv
tb/roi_pixel_statistics_core_tb.sv
